// ----- rtl/jump_statistic_bipower_window_macros.svh -----
// ----------------------------------------------------------------------------
// Jump statistic assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef JUMP_STATISTIC_BIPOWER_WINDOW_MACROS_SVH
`define JUMP_STATISTIC_BIPOWER_WINDOW_MACROS_SVH
`ifndef SYNTH
`define JSBW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define JSBW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define JSBW_ASSERT(lbl, prop, msg)
`define JSBW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/jsbw_pkg.sv -----
// ----------------------------------------------------------------------------
// Jump statistic package
// Register indexes, fixed-point constants and back-end state codes.
// ----------------------------------------------------------------------------
package jsbw_pkg;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_VOL_FLOOR     = 2'd1
  } cfg_reg_e;

  localparam logic [31:0] PI_HALF_Q31 = 32'd3373259426;
  localparam logic [30:0] MAG_MAX     = 31'h7FFF_FFFF;
  localparam logic [6:0]  WL_RESET    = 7'd16;
  localparam logic [30:0] FLOOR_RESET = 31'd1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SUM  = 8'b0000_0010,
    S_MEAN = 8'b0000_0100,
    S_MLO  = 8'b0000_1000,
    S_MHI  = 8'b0001_0000,
    S_ROOT = 8'b0010_0000,
    S_QUOT = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } back_state_e;

endpackage

// ----- rtl/jump_statistic_bipower_window.sv -----
// ----------------------------------------------------------------------------
// Jump statistic over a bipower window
// Local jump test: |r| over the root of the scaled bipower variance.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  input    | push / full            | return_value_i, series_start_i
//  result   | empty / pop            | jump_statistic_o, warming_up_o, below_floor_o
//  config   | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  Warm-up items go from idle straight to done in the back end; others run
//  a K-read product sweep over the history RAM with its pipeline drain,
//  64 divider steps for the mean, 2 multiplies, 32 root steps and 47
//  divider steps; an item at or below the floor skips the last 47.
//  The front takes one request a cycle while full is low, into a two-entry
//  queue; full rises only when that queue is full. A finished result waits
//  in the output register and stalls the back end. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module jump_statistic_bipower_window
  import jsbw_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned RETURN_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [RETURN_BITS-1:0] return_value_i,
  input  logic                   series_start_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [31:0]            jump_statistic_o,
  output logic                   warming_up_o,
  output logic                   below_floor_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WINDOW);
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned EW = 31 + AW + CW + 1;

  logic [6:0]    wl_q;
  logic [30:0]   floor_q;
  logic [EW-1:0] entry_in, entry_out;
  logic          q_empty, q_pop, accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q    <= WL_RESET;
      floor_q <= FLOOR_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_LENGTH: wl_q    <= cfg_data_i[6:0];
        REG_VOL_FLOOR:     floor_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  jsbw_front #(.MAX_WINDOW(MAX_WINDOW), .RETURN_BITS(RETURN_BITS)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .return_value_i  (return_value_i),
    .series_start_i  (series_start_i),
    .window_length_i (wl_q),
    .entry_o         (entry_in)
  );

  jsbw_fifo #(.WIDTH(EW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (entry_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .rdata_o (entry_out),
    .empty_o (q_empty)
  );

  jsbw_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (entry_out),
    .entry_empty_i (q_empty),
    .entry_pop_o   (q_pop),
    .floor_i       (floor_q),
    .pop_i         (pop),
    .empty_o       (empty),
    .stat_o        (jump_statistic_o),
    .warm_o        (warming_up_o),
    .low_o         (below_floor_o)
  );

endmodule

// ----- rtl/jsbw_ram.sv -----
// ----------------------------------------------------------------------------
// Jump statistic generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module jsbw_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/jsbw_fifo.sv -----
// ----------------------------------------------------------------------------
// Jump statistic request queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module jsbw_fifo #(
  parameter int unsigned WIDTH = 46
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] ent_q [2];
  logic             wp_q, wp_d, rp_q, rp_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = ent_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d  = do_push ? ~wp_q : wp_q;
    rp_d  = do_pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/jsbw_front.sv -----
// ----------------------------------------------------------------------------
// Jump statistic front end
// Takes magnitude, tracks series position and ring slot, flags warm-up.
// ----------------------------------------------------------------------------
module jsbw_front
  import jsbw_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned RETURN_BITS = 32,
  localparam int unsigned AW = $clog2(MAX_WINDOW),
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1),
  localparam int unsigned EW = 31 + AW + CW + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [RETURN_BITS-1:0] return_value_i,
  input  logic                   series_start_i,
  input  logic [6:0]             window_length_i,
  output logic [EW-1:0]          entry_o
);

  logic [CW-1:0]          seen_q, seen_d, seen_eff;
  logic [AW-1:0]          ptr_q, ptr_d, ptr_eff;
  logic [RETURN_BITS-1:0] neg;
  logic [31:0]            mag32;
  logic [30:0]            mag;
  logic [CW-1:0]          k;
  logic                   warm;

  always_comb begin
    neg   = return_value_i[RETURN_BITS-1] ? (~return_value_i + 1'b1) : return_value_i;
    mag32 = 32'(neg);
    mag   = mag32[31] ? MAG_MAX : mag32[30:0];

    if (window_length_i < 7'd2) begin
      k = CW'(2);
    end else if (32'(window_length_i) > 32'(MAX_WINDOW)) begin
      k = CW'(MAX_WINDOW);
    end else begin
      k = CW'(window_length_i);
    end

    seen_eff = series_start_i ? '0 : seen_q;
    ptr_eff  = series_start_i ? '0 : ptr_q;
    warm     = (seen_eff < k);

    ptr_d  = (32'(ptr_eff) + 32'd1 >= 32'(MAX_WINDOW)) ? '0 : ptr_eff + 1'b1;
    seen_d = (32'(seen_eff) < 32'(MAX_WINDOW)) ? seen_eff + 1'b1 : seen_eff;
  end

  assign entry_o = {mag, ptr_eff, k, warm};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      ptr_q  <= '0;
    end else if (accept_i) begin
      seen_q <= seen_d;
      ptr_q  <= ptr_d;
    end
  end

endmodule

// ----- rtl/jsbw_back.sv -----
// ----------------------------------------------------------------------------
// Jump statistic back end
// Window product sweep, mean, pi/2 scaling, square root and final quotient.
// ----------------------------------------------------------------------------
`include "jump_statistic_bipower_window_macros.svh"

module jsbw_back
  import jsbw_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 64,
  localparam int unsigned AW = $clog2(MAX_WINDOW),
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1),
  localparam int unsigned EW = 31 + AW + CW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [EW-1:0] entry_i,
  input  logic          entry_empty_i,
  output logic          entry_pop_o,
  input  logic [30:0]   floor_i,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [31:0]   stat_o,
  output logic          warm_o,
  output logic          low_o
);

  back_state_e state_q, state_d;

  logic [30:0]   a_q;
  logic [AW-1:0] ptr_q;
  logic [CW-1:0] k_q, iss_q;
  logic          warm_q, low_q;
  logic          rd_v_q, have_prev_q, prod_v_q;
  logic [30:0]   prev_q;
  logic [61:0]   prod_q;
  logic [63:0]   sum_q;
  logic [63:0]   num_q, num_d;
  logic [31:0]   rem_q, rem_d, div_q;
  logic [6:0]    cnt_q;
  logic [63:0]   plo_q;
  logic [63:0]   op_q, res_q, op_d, res_d, bitv, trial;
  logic          res_v_q;
  logic [32:0]   rem_sh;
  logic          ge;

  logic [30:0]   e_mag;
  logic [AW-1:0] e_ptr;
  logic [CW-1:0] e_k;
  logic          e_warm;

  logic          ram_re, ram_we;
  logic [AW-1:0] raddr;
  logic [30:0]   rdata;
  logic [31:0]   addr_tmp;
  logic          out_free;
  logic [31:0]   stat_calc;

  assign {e_mag, e_ptr, e_k, e_warm} = entry_i;
  assign empty_o  = !res_v_q;
  assign out_free = !res_v_q || pop_i;

  jsbw_ram #(.WIDTH(31), .DEPTH(MAX_WINDOW)) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (a_q),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    addr_tmp = 32'(ptr_q) + 32'(MAX_WINDOW) - 32'(iss_q);
    if (addr_tmp >= 32'(MAX_WINDOW)) begin
      addr_tmp = addr_tmp - 32'(MAX_WINDOW);
    end
    raddr  = AW'(addr_tmp);
    ram_re = (state_q == S_SUM) && (iss_q != '0);
    ram_we = (state_q == S_DONE) && out_free;

    // restoring divider step
    rem_sh = {rem_q, num_q[63]};
    ge     = (rem_sh >= {1'b0, div_q});
    rem_d  = ge ? 32'(rem_sh - {1'b0, div_q}) : rem_sh[31:0];
    num_d  = {num_q[62:0], ge};

    // square root step
    bitv  = 64'd1 << {cnt_q[4:0], 1'b0};
    trial = res_q + bitv;
    if (op_q >= trial) begin
      op_d  = op_q - trial;
      res_d = (res_q >> 1) + bitv;
    end else begin
      op_d  = op_q;
      res_d = res_q >> 1;
    end

    stat_calc = (|num_q[46:32]) ? 32'hFFFF_FFFF : num_q[31:0];

    entry_pop_o = (state_q == S_IDLE) && !entry_empty_i;
    state_d     = state_q;
    unique case (state_q)
      S_IDLE: if (!entry_empty_i) state_d = e_warm ? S_DONE : S_SUM;
      S_SUM:  if (iss_q == '0 && !rd_v_q && !prod_v_q) state_d = S_MEAN;
      S_MEAN: if (cnt_q == 7'd0) state_d = S_MLO;
      S_MLO:  state_d = S_MHI;
      S_MHI:  state_d = S_ROOT;
      S_ROOT: begin
        if (cnt_q == 7'd0) begin
          state_d = (res_d[31:0] <= 32'(floor_i)) ? S_DONE : S_QUOT;
        end
      end
      S_QUOT: if (cnt_q == 7'd0) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_v_q     <= 1'b0;
      rd_v_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      have_prev_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        res_v_q <= 1'b1;
      end else if (pop_i) begin
        res_v_q <= 1'b0;
      end
      if (state_q == S_IDLE) begin
        rd_v_q      <= 1'b0;
        prod_v_q    <= 1'b0;
        have_prev_q <= 1'b0;
      end else begin
        rd_v_q   <= ram_re;
        prod_v_q <= rd_v_q && have_prev_q;
        if (rd_v_q) begin
          have_prev_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        a_q    <= e_mag;
        ptr_q  <= e_ptr;
        k_q    <= e_k;
        iss_q  <= e_k;
        warm_q <= e_warm;
        low_q  <= 1'b0;
        sum_q  <= '0;
      end
      S_SUM: begin
        if (ram_re) begin
          iss_q <= iss_q - 1'b1;
        end
        if (rd_v_q) begin
          prev_q <= rdata;
          prod_q <= prev_q * rdata;
        end
        if (prod_v_q) begin
          sum_q <= sum_q + 64'(prod_q[61:8]);
        end
        num_q <= sum_q + (prod_v_q ? 64'(prod_q[61:8]) : 64'd0);
        rem_q <= '0;
        div_q <= 32'(k_q - 1'b1);
        cnt_q <= 7'd63;
      end
      S_MEAN: begin
        num_q <= num_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q - 7'd1;
      end
      S_MLO: plo_q <= 64'(num_q[31:0]) * 64'(PI_HALF_Q31);
      S_MHI: begin
        op_q  <= (64'(num_q[63:32]) * 64'(PI_HALF_Q31) << 9)
               + 64'({plo_q[63:31], 8'd0});
        cnt_q <= 7'd31;
        res_q <= '0;
      end
      S_ROOT: begin
        op_q  <= op_d;
        res_q <= res_d;
        if (cnt_q == 7'd0) begin
          low_q <= (res_d[31:0] <= 32'(floor_i));
          div_q <= res_d[31:0];
          num_q <= {a_q, 33'd0};
          rem_q <= '0;
          cnt_q <= 7'd46;
        end else begin
          cnt_q <= cnt_q - 7'd1;
        end
      end
      S_QUOT: begin
        num_q <= num_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q - 7'd1;
      end
      S_DONE: begin
        if (out_free) begin
          stat_o <= (warm_q || low_q) ? 32'd0 : stat_calc;
          warm_o <= warm_q;
          low_o  <= low_q;
        end
      end
      default: ;
    endcase
  end

  `JSBW_ASSERT(a_sweep_bound, (state_q == S_SUM) |-> (iss_q <= k_q), "sweep past window")
  `JSBW_ASSERT(a_quot_above_floor, (state_q == S_QUOT) |-> (div_q > 32'(floor_i)), "low divide")
  `JSBW_ASSERT(a_done_holds, (state_q == S_DONE && res_v_q && !pop_i) |=> (state_q == S_DONE), "lost")
  `JSBW_ASSERT(a_flags_excl, res_v_q |-> !(warm_o && low_o), "warm-up and floor both set")

endmodule
